// File: rtl/bcl_pkg.sv
// Shared constants and types of the block cache tag engine.
`default_nettype none

package bcl_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned SLOT_OUT_W  = 6;
  localparam int unsigned BLOCK_OUT_W = 32;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic update;
    logic promote;
    logic flush;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bcl_cell.sv
// One recency list position: holds a slot id with its tag, valid and dirty bits.
`default_nettype none

module bcl_cell import bcl_pkg::*; #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned BLOCK_BITS = 32,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cell_ctrl_t                    ctrl_i,
  input  wire logic [$clog2(SLOTS)-1:0]      pos_i,
  input  wire logic [$clog2(SLOTS)-1:0]      flush_idx_i,
  input  wire logic [BLOCK_BITS-1:0]         lookup_tag_i,
  input  wire logic [$clog2(SLOTS)-1:0]      load_slot_i,
  input  wire logic [BLOCK_BITS-1:0]         load_tag_i,
  input  wire logic                          load_valid_i,
  input  wire logic                          load_dirty_i,
  input  wire logic [$clog2(SLOTS)-1:0]      prev_slot_i,
  input  wire logic [BLOCK_BITS-1:0]         prev_tag_i,
  input  wire logic                          prev_valid_i,
  input  wire logic                          prev_dirty_i,
  output logic      [$clog2(SLOTS)-1:0]      slot_o,
  output logic      [BLOCK_BITS-1:0]         tag_o,
  output logic                               valid_o,
  output logic                               dirty_o,
  output logic                               match_o,
  output logic                               flush_hit_o,
  output logic                               flush_later_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam logic [SW-1:0] IDX = SW'(INDEX);

  logic [SW-1:0]         slot_q, slot_d;
  logic [BLOCK_BITS-1:0] tag_q, tag_d;
  logic                  valid_q, valid_d;
  logic                  dirty_q, dirty_d;
  logic                  take_prev, take_load, clear;

  assign match_o       = valid_q && (tag_q == lookup_tag_i);
  assign flush_hit_o   = valid_q && dirty_q && (slot_q == flush_idx_i);
  assign flush_later_o = valid_q && dirty_q && (slot_q > flush_idx_i);

  assign take_prev = ctrl_i.update && ctrl_i.promote && (IDX <= pos_i);
  assign take_load = ctrl_i.update && !ctrl_i.promote && (IDX == pos_i);
  assign clear     = ctrl_i.flush && flush_hit_o;

  always_comb begin
    slot_d  = slot_q;
    tag_d   = tag_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (take_prev) begin
      slot_d  = prev_slot_i;
      tag_d   = prev_tag_i;
      valid_d = prev_valid_i;
      dirty_d = prev_dirty_i;
    end else if (take_load) begin
      slot_d  = load_slot_i;
      tag_d   = load_tag_i;
      valid_d = load_valid_i;
      dirty_d = load_dirty_i;
    end else if (clear) begin
      valid_d = 1'b0;
      dirty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= IDX;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign slot_o  = slot_q;
  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign dirty_o = dirty_q;

endmodule

`default_nettype wire

// File: rtl/block_cache_lazy_lru.sv
// Top level of the fully associative write-back block cache tag engine.
//
// Usage:
//   Command channel: an item (operation_i, block_number_i) is taken at a clock
//   edge with start high and busy low. Read and write accesses: the accept
//   edge registers the parallel tag compare of all list cells, the next edge
//   reorders the cell row and registers the result; busy stays high until
//   then, so a new item can start only after the result is registered.
//   Flush sweeps slot ids 0..SLOTS-1 one per cycle through the cell row and
//   stops after the last dirty slot. With nothing dirty it answers at the
//   accept edge.
//   Results: result_valid_o marks each word for exactly one cycle; the
//   receiver takes it then and cannot hold it off. An access gives one word,
//   registered in the update state; flush gives at most one word per cycle.
//   Configuration: cfg_data_i is written to promote_depth when cfg_valid_i is
//   high; cfg_ready_o is always high. Write it only while idle.
//   Reset: all slots invalid and clean, list position i holds slot i,
//   promote_depth = SLOTS/4. No clearing pass is needed.
`default_nettype none

module block_cache_lazy_lru import bcl_pkg::*; #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned BLOCK_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          operation_i,
  input  wire logic [BLOCK_OUT_W-1:0]   block_number_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [DEPTH_W-1:0]       cfg_data_i,
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic      [SLOT_OUT_W-1:0]    slot_o,
  output logic                          fill_o,
  output logic                          writeback_o,
  output logic      [BLOCK_OUT_W-1:0]   writeback_block_o,
  output logic                          last_o
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned BB    = BLOCK_BITS;
  localparam int unsigned CMP_W = (SW > DEPTH_W) ? SW : DEPTH_W;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(SLOTS / 4);
  localparam logic [SLOTS-1:0]   TAIL_OH     = {1'b1, {(SLOTS-1){1'b0}}};
  localparam logic [SW-1:0]      LAST_IDX    = SW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [DEPTH_W-1:0] depth_q;
  logic [SLOTS-1:0]   match_q;
  logic [BB-1:0]      blk_q;
  logic               write_q;
  logic [SW-1:0]      idx_q, idx_d;

  logic [SW-1:0]    cell_slot [SLOTS];
  logic [BB-1:0]    cell_tag  [SLOTS];
  logic [SLOTS-1:0] cell_valid, cell_dirty, cell_match, cell_fhit, cell_flater;

  logic [BB+BLOCK_OUT_W-1:0] blk_wide;
  logic [BB-1:0]             blk;
  logic                      accept;

  logic             acc_hit;
  logic [SLOTS-1:0] sel_oh;
  logic [SW-1:0]    sel_slot, pos;
  logic [BB-1:0]    sel_tag;
  logic             sel_valid, sel_dirty;
  logic [CMP_W+SW-1:0]      pos_wide;
  logic [CMP_W+DEPTH_W-1:0] depth_wide;
  logic             promote;
  logic [SW-1:0]    e_slot;
  logic [BB-1:0]    e_tag;
  logic             e_valid, e_dirty;
  logic [BB-1:0]    f_tag;
  logic             f_any, f_last, any_dirty;
  cell_ctrl_t       ctrl;

  logic                    res_valid_d, res_valid_q;
  logic                    hit_d, hit_q;
  logic [SW-1:0]           slot_d;
  logic [SW+SLOT_OUT_W-1:0] slot_wide;
  logic [SLOT_OUT_W-1:0]   slot_q;
  logic                    fill_d, fill_q;
  logic                    wb_d, wb_q;
  logic [BB-1:0]           wb_blk_d;
  logic [BB+BLOCK_OUT_W-1:0] wb_blk_wide;
  logic [BLOCK_OUT_W-1:0]  wb_blk_q;
  logic                    last_d, last_q;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign blk_wide = {{BB{1'b0}}, block_number_i};
  assign blk      = blk_wide[BB-1:0];

  for (genvar p = 0; p < SLOTS; p++) begin : g_cell
    logic [SW-1:0] prev_slot;
    logic [BB-1:0] prev_tag;
    logic          prev_valid, prev_dirty;

    if (p == 0) begin : g_head
      assign prev_slot  = e_slot;
      assign prev_tag   = e_tag;
      assign prev_valid = e_valid;
      assign prev_dirty = e_dirty;
    end else begin : g_body
      assign prev_slot  = cell_slot[p-1];
      assign prev_tag   = cell_tag[p-1];
      assign prev_valid = cell_valid[p-1];
      assign prev_dirty = cell_dirty[p-1];
    end

    bcl_cell #(
      .SLOTS      (SLOTS),
      .BLOCK_BITS (BLOCK_BITS),
      .INDEX      (p)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .pos_i         (pos),
      .flush_idx_i   (idx_q),
      .lookup_tag_i  (blk),
      .load_slot_i   (e_slot),
      .load_tag_i    (e_tag),
      .load_valid_i  (e_valid),
      .load_dirty_i  (e_dirty),
      .prev_slot_i   (prev_slot),
      .prev_tag_i    (prev_tag),
      .prev_valid_i  (prev_valid),
      .prev_dirty_i  (prev_dirty),
      .slot_o        (cell_slot[p]),
      .tag_o         (cell_tag[p]),
      .valid_o       (cell_valid[p]),
      .dirty_o       (cell_dirty[p]),
      .match_o       (cell_match[p]),
      .flush_hit_o   (cell_fhit[p]),
      .flush_later_o (cell_flater[p])
    );
  end

  assign acc_hit = |match_q;
  assign sel_oh  = acc_hit ? match_q : TAIL_OH;

  always_comb begin
    sel_slot  = '0;
    sel_tag   = '0;
    sel_valid = 1'b0;
    sel_dirty = 1'b0;
    pos       = '0;
    f_tag     = '0;
    for (int p = 0; p < SLOTS; p++) begin
      if (sel_oh[p]) begin
        sel_slot  = sel_slot | cell_slot[p];
        sel_tag   = sel_tag | cell_tag[p];
        sel_valid = sel_valid | cell_valid[p];
        sel_dirty = sel_dirty | cell_dirty[p];
        pos       = pos | SW'(p);
      end
      if (cell_fhit[p]) begin
        f_tag = f_tag | cell_tag[p];
      end
    end
  end

  assign pos_wide   = {{CMP_W{1'b0}}, pos};
  assign depth_wide = {{CMP_W{1'b0}}, depth_q};
  assign promote    = !acc_hit || (pos_wide[CMP_W-1:0] > depth_wide[CMP_W-1:0]);

  assign e_slot  = sel_slot;
  assign e_tag   = acc_hit ? sel_tag : blk_q;
  assign e_valid = 1'b1;
  assign e_dirty = (acc_hit && sel_dirty) || write_q;

  assign f_any     = |cell_fhit;
  assign f_last    = !(|cell_flater);
  assign any_dirty = |(cell_valid & cell_dirty);

  assign ctrl.update  = (state_q == ST_UPDATE);
  assign ctrl.promote = promote;
  assign ctrl.flush   = (state_q == ST_FLUSH);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    hit_d       = 1'b0;
    slot_d      = '0;
    fill_d      = 1'b0;
    wb_d        = 1'b0;
    wb_blk_d    = '0;
    last_d      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_READ || operation_i == OP_WRITE) begin
            state_d = ST_UPDATE;
          end else if (operation_i == OP_FLUSH) begin
            idx_d = '0;
            if (any_dirty) begin
              state_d = ST_FLUSH;
            end else begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
            end
          end
        end
      end
      ST_UPDATE: begin
        res_valid_d = 1'b1;
        hit_d       = acc_hit;
        slot_d      = e_slot;
        fill_d      = !acc_hit;
        wb_d        = !acc_hit && sel_valid && sel_dirty;
        wb_blk_d    = wb_d ? sel_tag : '0;
        last_d      = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_FLUSH: begin
        if (f_any) begin
          res_valid_d = 1'b1;
          slot_d      = idx_q;
          wb_d        = 1'b1;
          wb_blk_d    = f_tag;
          last_d      = f_last;
        end
        idx_d = idx_q + SW'(1);
        if ((f_any && f_last) || idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign slot_wide   = {{SLOT_OUT_W{1'b0}}, slot_d};
  assign wb_blk_wide = {{BLOCK_OUT_W{1'b0}}, wb_blk_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= DEPTH_RESET;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        depth_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      match_q <= cell_match;
      blk_q   <= blk;
      write_q <= (operation_i == OP_WRITE);
    end
    if (res_valid_d) begin
      hit_q    <= hit_d;
      slot_q   <= slot_wide[SLOT_OUT_W-1:0];
      fill_q   <= fill_d;
      wb_q     <= wb_d;
      wb_blk_q <= wb_blk_wide[BLOCK_OUT_W-1:0];
      last_q   <= last_d;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign hit_o             = hit_q;
  assign slot_o            = slot_q;
  assign fill_o            = fill_q;
  assign writeback_o       = wb_q;
  assign writeback_block_o = wb_blk_q;
  assign last_o            = last_q;

endmodule

`default_nettype wire

// File: verif/tb_block_cache_lazy_lru.sv
// Self-checking testbench for the block cache tag engine with lazy LRU promotion.
`default_nettype none

module tb_block_cache_lazy_lru;
  import bcl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned NSLOT = 64;
  localparam int unsigned PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 63;
  localparam int unsigned SETTLE = 80;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   fill;
    logic                   writeback;
    logic [BLOCK_OUT_W-1:0] writeback_block;
    logic                   last;
  } cache_word_t;

  class tag_engine_shadow;
    logic [DEPTH_W-1:0]     promote_depth;
    logic [BLOCK_OUT_W-1:0] tag [NSLOT];
    bit                     valid [NSLOT];
    bit                     dirty [NSLOT];
    logic [SLOT_OUT_W-1:0]  order [NSLOT];
    cache_word_t            due_words [$];
    int                     mismatches;

    function new();
      promote_depth = DEPTH_W'(NSLOT / 4);
      for (int i = 0; i < NSLOT; i++) begin
        tag[i] = '0;
        valid[i] = 0;
        dirty[i] = 0;
        order[i] = SLOT_OUT_W'(i);
      end
      mismatches = 0;
    endfunction

    function void set_depth(logic [DEPTH_W-1:0] v);
      promote_depth = v;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void take_command(logic [OP_W-1:0] op, logic [BLOCK_OUT_W-1:0] blk);
      int pos;
      int s;
      bit found;
      bit promote;
      int n;
      logic [SLOT_OUT_W-1:0] moved;
      cache_word_t w;
      found = 0;
      pos = 0;
      s = 0;
      w = '0;
      if (op == OP_READ || op == OP_WRITE) begin
        for (int p = 0; p < NSLOT && !found; p++) begin
          if (valid[order[p]] && tag[order[p]] == blk) begin
            found = 1;
            pos = p;
            s = order[p];
          end
        end
        if (!found) begin
          pos = NSLOT - 1;
          s = order[pos];
          if (valid[s] && dirty[s]) begin
            w.writeback = 1;
            w.writeback_block = tag[s];
          end
          tag[s] = blk;
          valid[s] = 1;
          dirty[s] = 0;
          promote = 1;
        end else begin
          promote = pos > promote_depth;
        end
        if (promote && pos != 0) begin
          moved = order[pos];
          for (int i = pos; i > 0; i--) order[i] = order[i-1];
          order[0] = moved;
        end
        if (op == OP_WRITE) dirty[s] = 1;
        w.hit = found;
        w.slot = SLOT_OUT_W'(s);
        w.fill = !found;
        w.last = 1;
        due_words.push_back(w);
      end else if (op == OP_FLUSH) begin
        n = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (valid[i] && dirty[i]) begin
            w = '0;
            w.slot = SLOT_OUT_W'(i);
            w.writeback = 1;
            w.writeback_block = tag[i];
            due_words.push_back(w);
            valid[i] = 0;
            dirty[i] = 0;
            n++;
          end
        end
        if (n == 0) begin
          w = '0;
          w.last = 1;
          due_words.push_back(w);
        end else begin
          due_words[due_words.size()-1].last = 1;
        end
      end
    endfunction

    function void report(string what, cache_word_t exp, cache_word_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected hit=%0d slot=%0d fill=%0d wb=%0d wb_block=%h last=%0d",
                 what, exp.hit, exp.slot, exp.fill, exp.writeback, exp.writeback_block,
                 exp.last);
        $display("  got hit=%0d slot=%0d fill=%0d wb=%0d wb_block=%h last=%0d",
                 got.hit, got.slot, got.fill, got.writeback, got.writeback_block, got.last);
      end
    endfunction

    function void check_word(cache_word_t got);
      cache_word_t exp;
      if (due_words.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        exp = due_words.pop_front();
        if (got.hit !== exp.hit || got.slot !== exp.slot || got.fill !== exp.fill ||
            got.writeback !== exp.writeback ||
            got.writeback_block !== exp.writeback_block || got.last !== exp.last)
          report("word mismatch", exp, got);
      end
    endfunction

    function void close_out();
      while (due_words.size() != 0) report("missing word", due_words.pop_front(), '0);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OP_W-1:0]        operation_i = '0;
  logic [BLOCK_OUT_W-1:0] block_number_i = '0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [DEPTH_W-1:0]     cfg_data_i = '0;
  logic                   result_valid_o;
  logic                   hit_o;
  logic [SLOT_OUT_W-1:0]  slot_o;
  logic                   fill_o;
  logic                   writeback_o;
  logic [BLOCK_OUT_W-1:0] writeback_block_o;
  logic                   last_o;

  tag_engine_shadow shadow = new();
  int unsigned cycles = 0;
  logic [BLOCK_OUT_W-1:0] block_pool [80];

  block_cache_lazy_lru dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .block_number_i   (block_number_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .hit_o            (hit_o),
    .slot_o           (slot_o),
    .fill_o           (fill_o),
    .writeback_o      (writeback_o),
    .writeback_block_o(writeback_block_o),
    .last_o           (last_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("block_cache_lazy_lru test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) shadow.take_command(operation_i, block_number_i);
      if (cfg_valid_i && cfg_ready_o) shadow.set_depth(cfg_data_i);
      if (result_valid_o)
        shadow.check_word('{hit_o, slot_o, fill_o, writeback_o, writeback_block_o, last_o});
    end
  end

  task automatic issue(input logic [OP_W-1:0] op, input logic [BLOCK_OUT_W-1:0] blk,
                       input bit may_idle);
    if (may_idle && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    block_number_i <= blk;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [DEPTH_W-1:0] depth_plan [PHASES];
    logic [OP_W-1:0] op;
    logic [BLOCK_OUT_W-1:0] blk;
    int unsigned pool_size;
    int unsigned done;
    int unsigned roll;
    bit idle_ok;

    depth_plan = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd40, 7'd0, 7'd16};
    block_pool[0] = 32'h0000_0000;
    block_pool[1] = 32'hFFFF_FFFF;
    block_pool[2] = 32'hAAAA_AAAA;
    block_pool[3] = 32'h5555_5555;
    for (int i = 4; i < 80; i++) block_pool[i] = $urandom();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(OP_FLUSH, 32'h0, 1);
    issue(OP_READ, 32'h0000_0000, 1);
    issue(OP_READ, 32'h0000_0000, 1);
    issue(OP_WRITE, 32'hFFFF_FFFF, 1);
    issue(OP_WRITE, 32'hFFFF_FFFF, 0);
    issue(OP_READ, 32'hAAAA_AAAA, 0);
    issue(OP_WRITE, 32'h5555_5555, 1);
    issue(OP_UNUSED, 32'h1234_5678, 0);
    issue(OP_READ, 32'h0000_0000, 0);
    issue(OP_WRITE, 32'h8000_0001, 1);
    issue(OP_FLUSH, 32'hFFFF_FFFF, 0);
    issue(OP_FLUSH, 32'h0, 0);
    issue(OP_READ, 32'hFFFF_FFFF, 1);
    issue(OP_WRITE, 32'h0000_0000, 0);
    issue(OP_READ, 32'h7FFF_FFFE, 0);

    for (int p = 0; p < PHASES; p++) begin
      write_depth(p == 5 ? DEPTH_W'($urandom_range(127)) : depth_plan[p]);
      pool_size = $urandom_range(80, 24);
      idle_ok = (p != PHASES - 1);
      done = 0;
      while (done < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 46) op = OP_READ;
        else if (roll < 92) op = OP_WRITE;
        else if (roll < 97) op = OP_FLUSH;
        else op = OP_UNUSED;
        if ($urandom_range(99) < 8) blk = $urandom();
        else blk = block_pool[$urandom_range(pool_size - 1)];
        issue(op, blk, idle_ok && ($urandom_range(3) != 0));
        if (op != OP_UNUSED) done++;
      end
    end

    drain();
    shadow.close_out();
    if (shadow.mismatches == 0) begin
      $display("block_cache_lazy_lru test passed");
    end else begin
      $display("block_cache_lazy_lru test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
